/* design/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Types and constants shared by the periodic metadata scheduler.
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int NUM_CYCLERS = 5;
    localparam int IDX_W       = 3;
    localparam int CUR_W       = 64;
    localparam int VAL_W       = 32;

    // op codes
    localparam logic [1:0] OP_ADVANCE  = 2'd0;
    localparam logic [1:0] OP_ARM      = 2'd1;
    localparam logic [1:0] OP_DEFAULTS = 2'd2;

    // cycler slots
    localparam logic [IDX_W-1:0] IDX_PRIMARY   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SECONDARY = 3'd1;
    localparam logic [IDX_W-1:0] IDX_OP50      = 3'd2;
    localparam logic [IDX_W-1:0] IDX_VERSION   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_6E        = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LIMIT     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD      = 2'd0;
    localparam logic [1:0] CFG_DEF_VERSION = 2'd1;
    localparam logic [1:0] CFG_DEF_6E      = 2'd2;

    localparam logic [VAL_W-1:0] RST_DEF_VERSION = 32'd17171203;
    localparam logic [VAL_W-1:0] RST_DEF_6E      = 32'd2635097394;

    localparam logic [CUR_W-1:0] CUR_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CUR_W-1:0] CUR_VERSION_0 = 64'hFFFF_FFFF_FFFF_FFFF; // -1
    localparam logic [CUR_W-1:0] CUR_6E_0      = 64'hFFFF_FFFF_FFFF_FFFE; // -2

    typedef struct packed {
        logic [1:0]       op;
        logic [CUR_W-1:0] sample_end;
        logic [IDX_W-1:0] cycler_index;
        logic [VAL_W-1:0] arm_value;
    } in_word_t;

    typedef struct packed {
        logic sel_primary_mix;
        logic sel_secondary_downmix;
        logic sel_opcode_50;
        logic sel_encoder_version;
        logic sel_opcode_6e;
    } out_word_t;

endpackage

/* design/periodic_metadata_scheduler_core.sv */
// ----------------------------------------------------------------------------
// periodic_metadata_scheduler_core
// Five metadata cyclers that decide which metadata blocks go out per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one command word: advance a frame, arm one
//   cycler with a value, or load the preset values. Every accepted word
//   gives exactly one result word on m_valid/m_ready/m_data holding the
//   per-cycler fire flags (all zero for anything but an advance).
//   m_valid is set in the cycle after acceptance; throughput is one
//   word per cycle while m_ready is high. All cycler updates are done
//   in the accept cycle by the compare and saturating-add logic ahead
//   of the state registers. The result register is the only output stage:
//   s_ready is high while it is empty or being drained, so a stalled
//   receiver stalls the input after one word.
//   Configuration (period, presets) is written through cfg_wen/cfg_index/
//   cfg_wdata, no wait, by the user only while no word is in flight (unchecked).
//   Reset (aresetn low, synchronous) clears all cyclers, sets period to
//   zero and the presets to their default values.
// ----------------------------------------------------------------------------
module periodic_metadata_scheduler_core
    import pms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,

    input  logic       cfg_wen,
    input  logic [1:0] cfg_index,
    input  logic [VAL_W-1:0] cfg_wdata
);

    logic [VAL_W-1:0] period_reg;
    logic [VAL_W-1:0] def_version_reg;
    logic [VAL_W-1:0] def_6e_reg;

    logic [NUM_CYCLERS-1:0] enable_reg, enable_next;
    logic [VAL_W-1:0]       value_reg  [NUM_CYCLERS];
    logic [VAL_W-1:0]       value_next [NUM_CYCLERS];
    logic [CUR_W-1:0]       cursor_reg  [NUM_CYCLERS];
    logic [CUR_W-1:0]       cursor_next [NUM_CYCLERS];

    logic                   m_valid_reg;
    out_word_t              m_data_reg;
    logic [NUM_CYCLERS-1:0] fire;
    out_word_t              m_data_next;

    logic             s_fire;
    logic [CUR_W-1:0] end_sat;
    logic [CUR_W:0]   resched_sum;
    logic [CUR_W-1:0] resched_cur;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // frame end clamped to the positive cursor range
    assign end_sat = s_data.sample_end[CUR_W-1] ? CUR_MAX : s_data.sample_end;

    // next slot: end + period - 1, saturated (period is nonzero when used)
    assign resched_sum = {1'b0, s_data.sample_end}
                       + {{(CUR_W+1-VAL_W){1'b0}}, period_reg - 1'b1};
    assign resched_cur = (resched_sum[CUR_W] || resched_sum[CUR_W-1]) ?
                         CUR_MAX : resched_sum[CUR_W-1:0];

    always_comb begin
        enable_next = enable_reg;
        fire        = '0;
        for (int k = 0; k < NUM_CYCLERS; k++) begin
            value_next[k]  = value_reg[k];
            cursor_next[k] = cursor_reg[k];
        end

        case (s_data.op)
            OP_ADVANCE: begin
                for (int k = 0; k < NUM_CYCLERS; k++) begin
                    fire[k] = (period_reg != '0) && enable_reg[k] &&
                              !cursor_reg[k][CUR_W-1] && (cursor_reg[k] < end_sat);
                    if (fire[k]) begin
                        cursor_next[k] = resched_cur;
                    end else if (cursor_reg[k][CUR_W-1] &&
                                 (k[IDX_W-1:0] != IDX_SECONDARY)) begin
                        cursor_next[k] = cursor_reg[k] + 1'b1;
                    end
                end
            end
            OP_ARM: begin
                for (int k = 0; k < NUM_CYCLERS; k++) begin
                    if ((s_data.cycler_index == k[IDX_W-1:0]) &&
                        (s_data.cycler_index < IDX_LIMIT) &&
                        (!enable_reg[k] || value_reg[k] != s_data.arm_value)) begin
                        enable_next[k] = 1'b1;
                        value_next[k]  = s_data.arm_value;
                        cursor_next[k] = '0;
                    end
                end
            end
            OP_DEFAULTS: begin
                if (!enable_reg[IDX_VERSION] || value_reg[IDX_VERSION] != def_version_reg) begin
                    enable_next[IDX_VERSION] = 1'b1;
                    value_next[IDX_VERSION]  = def_version_reg;
                    cursor_next[IDX_VERSION] = CUR_VERSION_0;
                end
                if (!enable_reg[IDX_6E] || value_reg[IDX_6E] != def_6e_reg) begin
                    enable_next[IDX_6E] = 1'b1;
                    value_next[IDX_6E]  = def_6e_reg;
                    cursor_next[IDX_6E] = CUR_6E_0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_data_next.sel_primary_mix       = fire[IDX_PRIMARY];
        m_data_next.sel_secondary_downmix = fire[IDX_SECONDARY];
        m_data_next.sel_opcode_50         = fire[IDX_OP50];
        m_data_next.sel_encoder_version   = fire[IDX_VERSION];
        m_data_next.sel_opcode_6e         = fire[IDX_6E];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= '0;
            def_version_reg <= RST_DEF_VERSION;
            def_6e_reg      <= RST_DEF_6E;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_PERIOD:      period_reg      <= cfg_wdata;
                CFG_DEF_VERSION: def_version_reg <= cfg_wdata;
                CFG_DEF_6E:      def_6e_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            for (int k = 0; k < NUM_CYCLERS; k++) begin
                value_reg[k]  <= '0;
                cursor_reg[k] <= '0;
            end
        end else if (s_fire) begin
            enable_reg <= enable_next;
            for (int k = 0; k < NUM_CYCLERS; k++) begin
                value_reg[k]  <= value_next[k];
                cursor_reg[k] <= cursor_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // every accepted word produces a result word
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted word left no result");

    // only an advance can fire a cycler
    a_idle_ops_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.op != OP_ADVANCE |=> m_data_reg == '0)
        else $error("non-advance word fired a cycler");

    // zero period blocks every cycler
    a_period_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && period_reg == '0 |=> m_data_reg == '0)
        else $error("cycler fired with zero period");

    // a disabled cycler never fires
    a_enabled_only: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (fire & ~enable_reg) == '0)
        else $error("disabled cycler fired");

    // the secondary downmix cursor is never given a negative value
    a_secondary_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !cursor_reg[IDX_SECONDARY][CUR_W-1])
        else $error("secondary downmix cursor went negative");

endmodule
